// ----- rtl/core/class_aware_nms_letterbox_assert.svh -----
// Assertion macros for the class-aware NMS letterbox block.
// Included by the top level; no other dependencies.
`ifndef CLASS_AWARE_NMS_LETTERBOX_ASSERT_SVH
`define CLASS_AWARE_NMS_LETTERBOX_ASSERT_SVH
`ifndef SYNTHESIS
`define CANMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("canms property violated");
`define CANMS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("canms forbidden condition seen");
`else
`define CANMS_ASSERT(lbl, clk, rstn, prop)
`define CANMS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- rtl/core/canms_pkg.sv -----
// Shared constants, types and helper functions of the class-aware NMS block.
// No dependencies.
package canms_pkg;

  localparam int MAX_CAND   = 64;
  localparam int IDX_W      = $clog2(MAX_CAND);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CLASS_BITS = 8;
  localparam int CLASS_W    = 8;
  localparam int SCORE_W    = 16;
  localparam int SC_W       = SCORE_W + CLASS_BITS;
  localparam int COORD_W    = 16;
  localparam int THR_W      = 16;
  localparam int INV_W      = 24;
  localparam int PAD_W      = 15;
  localparam int SRC_W      = 14;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = DIFF_W + INV_W + 1;
  localparam int OUT_XY_W   = 17;
  localparam int OUT_WH_W   = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IOU_THR   = 3'd0,
    CFG_INV_SCALE = 3'd1,
    CFG_PAD_LEFT  = 3'd2,
    CFG_PAD_TOP   = 3'd3,
    CFG_SRC_W     = 3'd4,
    CFG_SRC_H     = 3'd5
  } cfg_reg_e;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_FETCH = 8'b0000_0100,
    ST_GRAB  = 8'b0000_1000,
    ST_FLUSH = 8'b0001_0000,
    ST_SUPP  = 8'b0010_0000,
    ST_MAP1  = 8'b0100_0000,
    ST_MAP2  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } iou_tag_t;

  function automatic logic [OUT_XY_W-1:0] src_hi(input logic [SRC_W-1:0] src);
    logic [SRC_W+3:0] t;
    t = {src - SRC_W'(1), 4'b0000};
    if (src == '0) begin
      return '0;
    end else if (t > (SRC_W+4)'(2**OUT_XY_W - 1)) begin
      return '1;
    end else begin
      return t[OUT_XY_W-1:0];
    end
  endfunction

  function automatic logic [OUT_XY_W-1:0] map_coord(input logic signed [PROD_W-1:0] p,
                                                    input logic [OUT_XY_W-1:0] hi);
    logic [PROD_W-1:0]  r;
    logic [PROD_W-17:0] v;
    r = $unsigned(p) + PROD_W'(32768);
    v = r[PROD_W-1:16];
    if (p[PROD_W-1] || p == '0) begin
      return '0;
    end else if (v > (PROD_W-16)'(hi)) begin
      return hi;
    end else begin
      return v[OUT_XY_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/canms_iou.sv -----
// Five-stage overlap test: intersection against threshold times union.
// Depends on canms_pkg.
module canms_iou import canms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [THR_W-1:0] thr_i,
  input  box_t             a_box_i,
  input  box_t             b_box_i,
  input  iou_tag_t         tag_i,
  output iou_tag_t         hit_o,
  output logic             busy_o
);

  iou_tag_t s1_q, s2_q, s3_q, s4_q;

  logic signed [DIFF_W-1:0] iw, ih;
  logic [DIFF_W-1:0] iw_q, ih_q;
  logic signed [DIFF_W-1:0] wa_q, ha_q, wb_q, hb_q;
  logic [2*DIFF_W-1:0] inter2_q, inter3_q, inter4_q;
  logic signed [2*DIFF_W-1:0] area_a_q, area_b_q;
  logic signed [2*DIFF_W+1:0] uni;
  logic [2*DIFF_W+1:0] uni_q;
  logic pos_q, pos4_q;
  logic [THR_W+18-1:0] p_lo_q;
  logic [THR_W+17-1:0] p_hi_q;
  logic [51:0] lhs, rhs;

  function automatic logic signed [DIFF_W-1:0] sx(input logic signed [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  assign iw = ((a_box_i.right < b_box_i.right) ? sx(a_box_i.right) : sx(b_box_i.right))
            - ((a_box_i.left > b_box_i.left) ? sx(a_box_i.left) : sx(b_box_i.left));
  assign ih = ((a_box_i.bottom < b_box_i.bottom) ? sx(a_box_i.bottom) : sx(b_box_i.bottom))
            - ((a_box_i.top > b_box_i.top) ? sx(a_box_i.top) : sx(b_box_i.top));

  assign uni = (2*DIFF_W+2)'(area_a_q) + (2*DIFF_W+2)'(area_b_q)
             - $signed({2'b00, inter2_q});

  assign lhs = 52'({inter4_q, 16'h0000});
  assign rhs = 52'({p_hi_q, 18'h00000}) + 52'(p_lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      s3_q  <= '0;
      s4_q  <= '0;
      hit_o <= '0;
    end else begin
      s1_q        <= tag_i;
      s2_q        <= s1_q;
      s3_q        <= s2_q;
      s4_q        <= s3_q;
      hit_o.valid <= s4_q.valid && pos4_q && (lhs > rhs);
      hit_o.idx   <= s4_q.idx;
    end
  end

  always_ff @(posedge clk_i) begin
    iw_q     <= iw[DIFF_W-1] ? '0 : iw;
    ih_q     <= ih[DIFF_W-1] ? '0 : ih;
    wa_q     <= sx(a_box_i.right) - sx(a_box_i.left);
    ha_q     <= sx(a_box_i.bottom) - sx(a_box_i.top);
    wb_q     <= sx(b_box_i.right) - sx(b_box_i.left);
    hb_q     <= sx(b_box_i.bottom) - sx(b_box_i.top);
    inter2_q <= iw_q * ih_q;
    area_a_q <= wa_q * ha_q;
    area_b_q <= wb_q * hb_q;
    uni_q    <= $unsigned(uni);
    pos_q    <= !uni[2*DIFF_W+1] && (uni != '0);
    inter3_q <= inter2_q;
    p_lo_q   <= thr_i * uni_q[17:0];
    p_hi_q   <= thr_i * uni_q[34:18];
    pos4_q   <= pos_q;
    inter4_q <= inter3_q;
  end

  assign busy_o = s1_q.valid || s2_q.valid || s3_q.valid || s4_q.valid || hit_o.valid;

endmodule

// ----- rtl/core/class_aware_nms_letterbox.sv -----
// Top level of the class-aware greedy NMS block with letterbox undo.
// Depends on canms_pkg, canms_iou and class_aware_nms_letterbox_assert.svh.
//
// Candidates arrive on the input channel (valid/stall), one transfer per
// cycle while loading; up to 64 are stored, further ones are dropped.
// The candidate carrying last_candidate closes the frame: input stalls
// until every kept box has been handed to the output register.
// Each walk step scans the score store for the best entry not yet
// visited or removed, then runs a suppression pass through the box
// store and the five-stage overlap unit, and maps the kept box in the
// MAP1 and MAP2 states. Each earlier result is flushed in the FLUSH
// state, and the pace of a frame is bounded by the single read port of
// each store. The result of a kept box leaves when the next one is
// found or when the frame ends, where it carries last_kept.
// The output register holds its transfer while out_stall_i is high; the
// walk waits for it only when the next result is ready to go.
// Reset empties the store, clears the removed flags and loads the
// register defaults; stored boxes need no clearing.
`include "class_aware_nms_letterbox_assert.svh"
module class_aware_nms_letterbox import canms_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [COORD_W-1:0]  left_i,
  input  logic signed [COORD_W-1:0]  top_i,
  input  logic signed [COORD_W-1:0]  right_i,
  input  logic signed [COORD_W-1:0]  bottom_i,
  input  logic [SCORE_W-1:0]         confidence_i,
  input  logic [CLASS_W-1:0]         obj_class_i,
  input  logic                       last_candidate_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [OUT_XY_W-1:0]        box_x_o,
  output logic [OUT_XY_W-1:0]        box_y_o,
  output logic signed [OUT_WH_W-1:0] box_w_o,
  output logic signed [OUT_WH_W-1:0] box_h_o,
  output logic [SCORE_W-1:0]         kept_score_o,
  output logic [CLASS_W-1:0]         kept_class_o,
  output logic                       last_kept_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  state_e state_q, state_d;

  logic [THR_W-1:0] thr_q;
  logic [INV_W-1:0] inv_q;
  logic [PAD_W-1:0] pad_l_q, pad_t_q;
  logic [SRC_W-1:0] src_w_q, src_h_q;

  logic [CNT_W-1:0]    cnt_q, iss_q;
  logic [MAX_CAND-1:0] done_q, removed_q;

  box_t             box_mem [MAX_CAND];
  logic [SC_W-1:0]  sc_mem  [MAX_CAND];
  box_t             box_rd_q;
  logic [SC_W-1:0]  sc_rd_q;
  logic             rd_v_q;
  logic [IDX_W-1:0] rd_idx_q, rd_addr;

  logic in_acc, out_acc, mem_we, issuing, scan_end, supp_end, out_free, frame_done;
  logic entry_open;

  logic               best_v_q;
  logic [IDX_W-1:0]   best_idx_q, sel_q;
  logic [SCORE_W-1:0] best_score_q;

  box_t                  a_box_q;
  logic [SCORE_W-1:0]    a_score_q;
  logic [CLASS_BITS-1:0] a_cls_q;
  logic                  close_q;

  iou_tag_t b_tag, hit_tag;
  logic     iou_busy;

  logic signed [DIFF_W-1:0] dx1, dy1, dx2, dy2;
  logic signed [PROD_W-1:0] px1_q, py1_q, px2_q, py2_q;
  logic [OUT_XY_W-1:0]      hi_x, hi_y, mx1, my1, mx2, my2;

  logic                       pend_v_q;
  logic [OUT_XY_W-1:0]        pend_x_q, pend_y_q;
  logic signed [OUT_WH_W-1:0] pend_w_q, pend_h_q;
  logic [SCORE_W-1:0]         pend_score_q;
  logic [CLASS_BITS-1:0]      pend_cls_q;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign mem_we     = in_acc && (cnt_q < CNT_W'(MAX_CAND));
  assign issuing    = (state_q == ST_SCAN || state_q == ST_SUPP) && (iss_q < cnt_q);
  assign scan_end   = (state_q == ST_SCAN) && !issuing && !rd_v_q;
  assign supp_end   = (state_q == ST_SUPP) && !issuing && !rd_v_q && !iou_busy;
  assign frame_done = (scan_end && !best_v_q && !pend_v_q)
                   || (state_q == ST_FLUSH && out_free && close_q);
  assign rd_addr    = (state_q == ST_FETCH) ? sel_q : iss_q[IDX_W-1:0];
  assign entry_open = rd_v_q && !done_q[rd_idx_q] && !removed_q[rd_idx_q];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_W'(29491);
      inv_q   <= INV_W'(65536);
      pad_l_q <= '0;
      pad_t_q <= '0;
      src_w_q <= SRC_W'(640);
      src_h_q <= SRC_W'(640);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IOU_THR:   thr_q   <= cfg_data_i[THR_W-1:0];
        CFG_INV_SCALE: inv_q   <= cfg_data_i[INV_W-1:0];
        CFG_PAD_LEFT:  pad_l_q <= cfg_data_i[PAD_W-1:0];
        CFG_PAD_TOP:   pad_t_q <= cfg_data_i[PAD_W-1:0];
        CFG_SRC_W:     src_w_q <= cfg_data_i[SRC_W-1:0];
        CFG_SRC_H:     src_h_q <= cfg_data_i[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  // candidate stores
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      box_mem[cnt_q[IDX_W-1:0]] <= '{left: left_i, top: top_i, right: right_i,
                                     bottom: bottom_i};
      sc_mem[cnt_q[IDX_W-1:0]]  <= {confidence_i, obj_class_i[CLASS_BITS-1:0]};
    end
    box_rd_q <= box_mem[rd_addr];
    sc_rd_q  <= sc_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (in_acc && last_candidate_i) state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          if (best_v_q)      state_d = ST_FETCH;
          else if (pend_v_q) state_d = ST_FLUSH;
          else               state_d = ST_LOAD;
        end
      end
      ST_FETCH: state_d = ST_GRAB;
      ST_GRAB:  state_d = pend_v_q ? ST_FLUSH : ST_SUPP;
      ST_FLUSH: if (out_free) state_d = close_q ? ST_LOAD : ST_SUPP;
      ST_SUPP:  if (supp_end) state_d = ST_MAP1;
      ST_MAP1:  state_d = ST_MAP2;
      ST_MAP2:  state_d = ST_SCAN;
      default:  state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      iss_q     <= '0;
      rd_v_q    <= 1'b0;
      done_q    <= '0;
      removed_q <= '0;
      best_v_q  <= 1'b0;
      close_q   <= 1'b0;
      pend_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issuing;
      if (mem_we) cnt_q <= cnt_q + CNT_W'(1);
      if (issuing) begin
        iss_q <= iss_q + CNT_W'(1);
      end else if (state_q != ST_SCAN && state_q != ST_SUPP) begin
        iss_q <= '0;
      end
      if (state_q != ST_SCAN) begin
        best_v_q <= 1'b0;
      end else if (entry_open
                   && (!best_v_q || sc_rd_q[SC_W-1 -: SCORE_W] > best_score_q)) begin
        best_v_q <= 1'b1;
      end
      if (scan_end) close_q <= !best_v_q;
      if (state_q == ST_FETCH) done_q[sel_q] <= 1'b1;
      if (hit_tag.valid) removed_q[hit_tag.idx] <= 1'b1;
      if (state_q == ST_MAP2) begin
        pend_v_q <= 1'b1;
      end else if (state_q == ST_FLUSH && out_free) begin
        pend_v_q <= 1'b0;
      end
      if (frame_done) begin
        cnt_q     <= '0;
        done_q    <= '0;
        removed_q <= '0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk_i) begin
    rd_idx_q <= iss_q[IDX_W-1:0];
    if (state_q == ST_SCAN && entry_open
        && (!best_v_q || sc_rd_q[SC_W-1 -: SCORE_W] > best_score_q)) begin
      best_idx_q   <= rd_idx_q;
      best_score_q <= sc_rd_q[SC_W-1 -: SCORE_W];
    end
    if (scan_end) sel_q <= best_idx_q;
    if (state_q == ST_GRAB) begin
      a_box_q   <= box_rd_q;
      a_score_q <= sc_rd_q[SC_W-1 -: SCORE_W];
      a_cls_q   <= sc_rd_q[CLASS_BITS-1:0];
    end
  end

  assign b_tag.valid = (state_q == ST_SUPP) && entry_open
                    && (sc_rd_q[CLASS_BITS-1:0] == a_cls_q);
  assign b_tag.idx   = rd_idx_q;

  canms_iou u_iou (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .thr_i   (thr_q),
    .a_box_i (a_box_q),
    .b_box_i (box_rd_q),
    .tag_i   (b_tag),
    .hit_o   (hit_tag),
    .busy_o  (iou_busy)
  );

  // letterbox undo
  assign dx1  = {a_box_q.left[COORD_W-1], a_box_q.left} - $signed({2'b00, pad_l_q});
  assign dy1  = {a_box_q.top[COORD_W-1], a_box_q.top} - $signed({2'b00, pad_t_q});
  assign dx2  = {a_box_q.right[COORD_W-1], a_box_q.right} - $signed({2'b00, pad_l_q});
  assign dy2  = {a_box_q.bottom[COORD_W-1], a_box_q.bottom} - $signed({2'b00, pad_t_q});
  assign hi_x = src_hi(src_w_q);
  assign hi_y = src_hi(src_h_q);
  assign mx1  = map_coord(px1_q, hi_x);
  assign my1  = map_coord(py1_q, hi_y);
  assign mx2  = map_coord(px2_q, hi_x);
  assign my2  = map_coord(py2_q, hi_y);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MAP1) begin
      px1_q <= dx1 * $signed({1'b0, inv_q});
      py1_q <= dy1 * $signed({1'b0, inv_q});
      px2_q <= dx2 * $signed({1'b0, inv_q});
      py2_q <= dy2 * $signed({1'b0, inv_q});
    end
    if (state_q == ST_MAP2) begin
      pend_x_q     <= mx1;
      pend_y_q     <= my1;
      pend_w_q     <= $signed({1'b0, mx2}) - $signed({1'b0, mx1});
      pend_h_q     <= $signed({1'b0, my2}) - $signed({1'b0, my1});
      pend_score_q <= a_score_q;
      pend_cls_q   <= a_cls_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == ST_FLUSH && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_acc) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FLUSH && out_free) begin
      box_x_o      <= pend_x_q;
      box_y_o      <= pend_y_q;
      box_w_o      <= pend_w_q;
      box_h_o      <= pend_h_q;
      kept_score_o <= pend_score_q;
      kept_class_o <= CLASS_W'(pend_cls_q);
      last_kept_o  <= close_q;
    end
  end

  `CANMS_ASSERT(a_load_clean, clk_i, rst_ni, (state_q == ST_LOAD) |-> (removed_q == '0 && done_q == '0))
  `CANMS_NEVER(a_no_self_hit, clk_i, rst_ni, hit_tag.valid && hit_tag.idx == sel_q)
  `CANMS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(MAX_CAND))

endmodule
